[rtl/core/three_level_ready_queue_scheduler_assert.svh]
// Assertion macros for the three-level ready-queue scheduler.
// Used by the port checker; no other dependencies.
`ifndef THREE_LEVEL_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define THREE_LEVEL_READY_QUEUE_SCHEDULER_ASSERT_SVH
// Clocked assertion with reset disable.
`define TLRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`endif

[rtl/core/tlrq_pkg.sv]
// Types, codes and helper functions of the ready-queue scheduler.
// No dependencies.
package tlrq_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_PICK   = 2'd1,
    ACT_AGE    = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_L1_FLOOR = 3'd0,
    CFG_L2_FLOOR = 3'd1,
    CFG_PRI_MAX  = 3'd2,
    CFG_WSTEP    = 3'd3,
    CFG_WLIMIT   = 3'd4,
    CFG_BONUS    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_PICK_SCAN, S_PICK_DEL, S_AGE_UPD,
    S_MOV_SCAN, S_MOV_APPLY, S_PRE_SCAN, S_DONE
  } state_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  localparam logic [11:0] WAIT_SAT = 12'hfff;

  typedef struct packed {
    logic [7:0]  l1_floor;
    logic [7:0]  l2_floor;
    logic [7:0]  pri_max;
    logic [11:0] wstep;
    logic [11:0] wlimit;
    logic [7:0]  bonus;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  thread;
    logic [7:0]  pri;
    logic [15:0] burst;
    logic [11:0] wait_t;
    logic [1:0]  level;
    logic [31:0] stamp;
    logic        mover;
    logic [1:0]  target;
    logic [7:0]  opri;
  } rec_t;

  function automatic logic [1:0] band_of(logic [7:0] p, cfg_t c);
    if (p >= c.l1_floor && p <= c.pri_max) return LVL_1;
    if (p >= c.l2_floor && p < c.l1_floor) return LVL_2;
    return LVL_3;
  endfunction

  // a ahead of b within level lvl; pa/pb are the priorities to order level 2 by
  function automatic logic ahead(rec_t a, rec_t b, logic [1:0] lvl,
                                 logic [7:0] pa, logic [7:0] pb);
    if (lvl == LVL_1 && a.burst != b.burst) return a.burst < b.burst;
    if (lvl == LVL_2 && pa != pb) return pa > pb;
    return a.stamp < b.stamp;
  endfunction

  function automatic rec_t age_rec(rec_t r, cfg_t c);
    rec_t        o;
    logic [12:0] sum;
    logic [8:0]  np;
    logic [1:0]  nl;
    o        = r;
    o.mover  = 1'b0;
    o.target = LVL_NONE;
    o.opri   = r.pri;
    sum      = {1'b0, r.wait_t} + {1'b0, c.wstep};
    np       = {1'b0, r.pri} + {1'b0, c.bonus};
    if (r.valid) begin
      if (sum >= {1'b0, c.wlimit}) begin
        o.wait_t = '0;
        if (r.pri < c.pri_max) begin
          o.pri = (np > {1'b0, c.pri_max}) ? c.pri_max : np[7:0];
        end
        nl = band_of(o.pri, c);
        if (nl < r.level) begin
          o.mover  = 1'b1;
          o.target = nl;
        end
      end else begin
        o.wait_t = sum[12] ? WAIT_SAT : sum[11:0];
      end
    end
    return o;
  endfunction

endpackage

[rtl/core/tlrq_cell.sv]
// One slot cell of the rotating thread table.
// Depends on tlrq_pkg.
module tlrq_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  tlrq_pkg::rec_t d_i,
  output tlrq_pkg::rec_t q_o
);
  import tlrq_pkg::*;

  rec_t rec_q;
  logic vld_q;

  // only the valid flag needs reset, payload is don't-care while invalid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= d_i;
    end
  end

  always_comb begin
    q_o       = rec_q;
    q_o.valid = vld_q;
  end

endmodule

[rtl/core/three_level_ready_queue_scheduler.sv]
// Top level of the three-level ready-queue scheduler: ring of slot cells
// plus the pass sequencer. Depends on tlrq_pkg and tlrq_cell.
//
//  channel | direction | handshake                 | payload
//  in      | in        | in_valid_i / in_stall_o   | action, thread id/priority/burst, running burst
//  out     | out       | out_valid_o / out_stall_i | status, picked valid/id/level, preempt
//  cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// The table rotates one cell per cycle past a single tap while a pass runs.
// Insert passes until a free slot takes the thread, pick scans then deletes,
// aging updates, then scans and applies per moved thread; each ends in a pre-scan.
// Reset empties the table, clears the entry counter and loads register defaults.
// A stalled result holds the block in its final state; no item is taken meanwhile.
module three_level_ready_queue_scheduler #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  thread_id_i,
  input  logic [7:0]  thread_priority_i,
  input  logic [15:0] thread_burst_i,
  input  logic [15:0] running_burst_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        picked_valid_o,
  output logic [7:0]  picked_id_o,
  output logic [1:0]  picked_level_o,
  output logic        preempt_o
);
  import tlrq_pkg::*;

  localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int VW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_DEPTH - 1);
  localparam logic [VW-1:0] FULL = VW'(TABLE_DEPTH);

  cfg_t   cfg_q;
  state_e state_q, state_d;
  rec_t   cq [TABLE_DEPTH];
  rec_t   tap, feed;
  logic   shift;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] vcnt_q, vcnt_d;
  logic [31:0]   ec_q, ec_d;
  rec_t          new_q;
  logic [15:0]   rburst_q;
  logic          bvld_q, bvld_d;
  rec_t          best_q, best_d;
  logic [1:0]    lvl_q, lvl_d;
  logic [1:0]    rstat_q, rstat_d;
  logic          rpv_q, rpv_d;
  logic [7:0]    rpid_q, rpid_d;
  logic [1:0]    rplvl_q, rplvl_d;
  logic          ovld_q;
  logic [1:0]    ostat_q;
  logic          opv_q, opre_q;
  logic [7:0]    opid_q;
  logic [1:0]    oplvl_q;

  logic accept, last, out_free, tap_l1, better, mov_hit;

  assign tap      = cq[0];
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign last     = (cnt_q == LAST);
  assign out_free = !ovld_q || !out_stall_i;
  assign tap_l1   = tap.valid && tap.level == LVL_1;
  // tap is a mover of the current level that goes ahead of the best so far
  assign mov_hit  = tap.valid && tap.mover && tap.level == lvl_q &&
                    (!bvld_q || ahead(tap, best_q, lvl_q, tap.opri, best_q.opri));

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rec_t din;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign din = feed;
    end else begin : g_mid
      assign din = cq[i+1];
    end
    tlrq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .d_i    (din),
      .q_o    (cq[i])
    );
  end

  // pick ordering: lower level first, then order within the level
  always_comb begin
    better = 1'b0;
    if (tap.valid) begin
      if (!bvld_q || tap.level < best_q.level) begin
        better = 1'b1;
      end else if (tap.level == best_q.level) begin
        better = ahead(tap, best_q, tap.level, tap.pri, best_q.pri);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_INSERT: state_d = (vcnt_q == FULL) ? S_PRE_SCAN : S_INS;
            ACT_PICK:   state_d = (vcnt_q == '0) ? S_PRE_SCAN : S_PICK_SCAN;
            ACT_AGE:    state_d = S_AGE_UPD;
            default:    state_d = S_PRE_SCAN;
          endcase
        end
      end
      S_INS:       if (!tap.valid) state_d = S_PRE_SCAN;
      S_PICK_SCAN: if (last) state_d = S_PICK_DEL;
      S_PICK_DEL: begin
        if (tap.valid && tap.stamp == best_q.stamp && tap.level == best_q.level) begin
          state_d = S_PRE_SCAN;
        end
      end
      S_AGE_UPD:   if (last) state_d = S_MOV_SCAN;
      S_MOV_SCAN: begin
        if (last) begin
          if (bvld_q || mov_hit) state_d = S_MOV_APPLY;
          else if (lvl_q == LVL_3) state_d = S_PRE_SCAN;
        end
      end
      S_MOV_APPLY: begin
        if (tap.valid && tap.mover && tap.stamp == best_q.stamp && tap.level == lvl_q) begin
          state_d = S_MOV_SCAN;
        end
      end
      S_PRE_SCAN:  if (last) state_d = S_DONE;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    shift   = 1'b0;
    feed    = tap;
    cnt_d   = cnt_q;
    vcnt_d  = vcnt_q;
    ec_d    = ec_q;
    bvld_d  = bvld_q;
    best_d  = best_q;
    lvl_d   = lvl_q;
    rstat_d = rstat_q;
    rpv_d   = rpv_q;
    rpid_d  = rpid_q;
    rplvl_d = rplvl_q;
    if (state_q != state_d) begin
      cnt_d  = '0;
      bvld_d = 1'b0;
    end else if (state_q != S_IDLE && state_q != S_DONE) begin
      cnt_d = last ? '0 : cnt_q + CW'(1);
    end
    case (state_q)
      S_IDLE: begin
        rstat_d = ST_OK;
        rpv_d   = 1'b0;
        rpid_d  = '0;
        rplvl_d = LVL_NONE;
        lvl_d   = LVL_2;
        if (accept && action_e'(action_i) == ACT_INSERT && vcnt_q == FULL) rstat_d = ST_FULL;
        if (accept && action_e'(action_i) == ACT_PICK && vcnt_q == '0) rstat_d = ST_EMPTY;
      end
      S_INS: begin
        shift = 1'b1;
        if (!tap.valid) begin
          feed       = new_q;
          feed.level = band_of(new_q.pri, cfg_q);
          feed.stamp = ec_q;
          ec_d       = ec_q + 32'd1;
          vcnt_d     = vcnt_q + VW'(1);
        end
      end
      S_PICK_SCAN: begin
        shift = 1'b1;
        if (better) begin
          bvld_d = 1'b1;
          best_d = tap;
        end
        if (last) bvld_d = 1'b1;
      end
      S_PICK_DEL: begin
        shift = 1'b1;
        if (tap.valid && tap.stamp == best_q.stamp && tap.level == best_q.level) begin
          feed.valid = 1'b0;
          vcnt_d     = vcnt_q - VW'(1);
          rpv_d      = 1'b1;
          rpid_d     = tap.thread;
          rplvl_d    = tap.level;
        end
      end
      S_AGE_UPD: begin
        shift = 1'b1;
        feed  = age_rec(tap, cfg_q);
      end
      S_MOV_SCAN: begin
        shift = 1'b1;
        if (mov_hit) begin
          bvld_d = 1'b1;
          best_d = tap;
        end
        if (last && !bvld_q && !mov_hit && lvl_q == LVL_2) lvl_d = LVL_3;
      end
      S_MOV_APPLY: begin
        shift = 1'b1;
        if (tap.valid && tap.mover && tap.stamp == best_q.stamp && tap.level == lvl_q) begin
          feed.mover = 1'b0;
          feed.level = tap.target;
          feed.stamp = ec_q;
          ec_d       = ec_q + 32'd1;
        end
      end
      S_PRE_SCAN: begin
        shift = 1'b1;
        // keep the level 1 minimum across the move into S_DONE
        if (last) bvld_d = bvld_q;
        // minimum level 1 burst is the level 1 head's burst
        if (tap_l1 && (!bvld_q || tap.burst < best_q.burst)) begin
          bvld_d = 1'b1;
          best_d = tap;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vcnt_q  <= '0;
      ec_q    <= '0;
      bvld_q  <= 1'b0;
      lvl_q   <= LVL_2;
      ovld_q  <= 1'b0;
      cfg_q   <= '{l1_floor: 8'd100, l2_floor: 8'd50, pri_max: 8'd149,
                   wstep: 12'd100, wlimit: 12'd1500, bonus: 8'd10};
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vcnt_q  <= vcnt_d;
      ec_q    <= ec_d;
      bvld_q  <= bvld_d;
      lvl_q   <= lvl_d;
      if (state_q == S_DONE && out_free) ovld_q <= 1'b1;
      else if (!out_stall_i) ovld_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_L1_FLOOR: cfg_q.l1_floor <= cfg_wdata_i[7:0];
          CFG_L2_FLOOR: cfg_q.l2_floor <= cfg_wdata_i[7:0];
          CFG_PRI_MAX:  cfg_q.pri_max  <= cfg_wdata_i[7:0];
          CFG_WSTEP:    cfg_q.wstep    <= cfg_wdata_i;
          CFG_WLIMIT:   cfg_q.wlimit   <= cfg_wdata_i;
          CFG_BONUS:    cfg_q.bonus    <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    rstat_q <= rstat_d;
    rpv_q   <= rpv_d;
    rpid_q  <= rpid_d;
    rplvl_q <= rplvl_d;
    if (accept) begin
      new_q    <= '{valid: 1'b1, thread: thread_id_i, pri: thread_priority_i,
                    burst: thread_burst_i, default: '0};
      rburst_q <= running_burst_i;
    end
    if (state_q == S_DONE && out_free) begin
      ostat_q <= rstat_q;
      opv_q   <= rpv_q;
      opid_q  <= rpid_q;
      oplvl_q <= rplvl_q;
      opre_q  <= bvld_q && (best_q.burst < rburst_q);
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ovld_q;
  assign status_o       = ostat_q;
  assign picked_valid_o = opv_q;
  assign picked_id_o    = opid_q;
  assign picked_level_o = oplvl_q;
  assign preempt_o      = opre_q;

endmodule

[rtl/core/tlrq_checker.sv]
// Port-level checker for the ready-queue scheduler, bound to the top level.
// Depends on tlrq_pkg and three_level_ready_queue_scheduler_assert.svh.
`include "three_level_ready_queue_scheduler_assert.svh"
module tlrq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       picked_valid_o,
  input logic [7:0] picked_id_o,
  input logic [1:0] picked_level_o
);
  import tlrq_pkg::*;

  `TLRQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `TLRQ_ASSERT(a_pick_ok, out_valid_o && picked_valid_o |-> status_o == ST_OK, "pick with bad status")
  `TLRQ_ASSERT(a_pick_lvl, out_valid_o && picked_valid_o |-> picked_level_o != LVL_NONE, "pick without level")
  `TLRQ_ASSERT(a_nopick_zero, out_valid_o && !picked_valid_o |-> picked_id_o == 8'd0 && picked_level_o == LVL_NONE, "stale pick fields")

endmodule

bind three_level_ready_queue_scheduler tlrq_checker u_tlrq_checker (.*);
